// File: sv/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ADJ_X = 3'd0;
  localparam logic [2:0] REG_ADJ_Y = 3'd1;
  localparam logic [2:0] REG_ADJ_Z = 3'd2;
  localparam logic [2:0] REG_HI_X  = 3'd3;
  localparam logic [2:0] REG_HI_Y  = 3'd4;
  localparam logic [2:0] REG_HI_Z  = 3'd5;

  // Scaled magnetometer axis: raw * (code + 128) + 16 * offset.
  localparam int MAG_W = 26;

  // How the accelerometer vector lies, which picks the heading formula.
  typedef enum logic [1:0] {
    TILT_GENERAL = 2'd0,
    TILT_LEVEL   = 2'd1,
    TILT_NONE    = 2'd2
  } tilt_kind_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    tilt_kind_t         kind;
  } tcc_item_t;

  // atan(2^-i) with 2^32 units per turn.
  localparam logic [31:0] ARC_TABLE [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Table angle rounded half up to a coarser turn.
  function automatic logic [31:0] arc_rounded(input logic [4:0] idx, input int sh);
    logic [32:0] sum;
    sum = {1'b0, ARC_TABLE[idx]} + (33'd1 << (sh - 1));
    return 32'(sum >> sh);
  endfunction

endpackage

`default_nettype wire

// File: sv/tcc_front.sv
`default_nettype none

module tcc_front import tcc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic signed [15:0] mag_x,
  input  wire logic signed [15:0] mag_y,
  input  wire logic signed [15:0] mag_z,
  input  wire logic               mag_ready,
  input  wire logic               mag_overflow,
  input  wire logic               q_full,
  output logic                    q_push,
  output tcc_item_t               q_item
);

  logic signed [15:0] held_x_r, held_y_r, held_z_r;
  logic               take_mag;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign take_mag = mag_ready && !mag_overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r <= '0;
      held_y_r <= '0;
      held_z_r <= '0;
    end else if (q_push && take_mag) begin
      held_x_r <= mag_x;
      held_y_r <= mag_y;
      held_z_r <= mag_z;
    end
  end

  always_comb begin
    q_item.ax = accel_x;
    q_item.ay = accel_y;
    q_item.az = accel_z;
    q_item.mx = take_mag ? mag_x : held_x_r;
    q_item.my = take_mag ? mag_y : held_y_r;
    q_item.mz = take_mag ? mag_z : held_z_r;
    if ((accel_y != '0) || (accel_z != '0)) begin
      q_item.kind = TILT_GENERAL;
    end else if (accel_x != '0) begin
      q_item.kind = TILT_LEVEL;
    end else begin
      q_item.kind = TILT_NONE;
    end
  end

endmodule

`default_nettype wire

// File: sv/tcc_fifo.sv
`default_nettype none

module tcc_fifo import tcc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  tcc_item_t      din,
  output logic           full,
  input  wire logic      pop,
  output tcc_item_t      dout,
  output logic           empty
);

  tcc_item_t  slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

endmodule

`default_nettype wire

// File: sv/tcc_mul.sv
`default_nettype none

module tcc_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] c,
  output logic             done,
  output logic [63:0]      p
);

  // p = c + a * b modulo 2^64, one 16-bit digit of b per cycle.
  localparam int DIG  = 16;
  localparam int NDIG = 64 / DIG;
  localparam int CW   = $clog2(NDIG + 1);

  logic [63:0]   a_r, b_r, acc_r, pp;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  assign pp   = a_r * 64'(b_r[DIG-1:0]);
  assign done = done_r;
  assign p    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NDIG);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= c;
    end else if (busy_r) begin
      acc_r <= acc_r + pp;
      a_r   <= a_r << DIG;
      b_r   <= b_r >> DIG;
    end
  end

endmodule

`default_nettype wire

// File: sv/tcc_cordic.sv
`default_nettype none

module tcc_cordic import tcc_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [63:0]        y_in,
  input  wire logic signed [63:0]        x_in,
  output logic                           done,
  output logic signed [ANGLE_BITS+1:0]   z_out
);

  localparam int ZW  = ANGLE_BITS + 2;
  localparam int NIT = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int IW  = $clog2(NIT);
  localparam int TSH = 32 - ANGLE_BITS;
  localparam logic signed [63:0] LIM_FINE   = 64'sh0080_0000_0000_0000;
  localparam logic signed [63:0] LIM_COARSE = 64'sh0000_8000_0000_0000;
  localparam logic signed [ZW-1:0] HALF    = ZW'(64'd1 << (ANGLE_BITS - 1));
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'd1 << (ANGLE_BITS - 2));

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_NORM = 3'b010,
    C_ITER = 3'b100
  } cor_state_t;

  cor_state_t           state_r;
  logic signed [63:0]   x_r, y_r, dx, dy;
  logic signed [ZW-1:0] z_r, arc_z;
  logic [IW-1:0]        it_r;
  logic                 done_r;
  logic                 fine_ok, coarse_ok;
  logic [31:0]          arc_full;

  assign fine_ok   = (x_r < LIM_FINE) && (x_r > -LIM_FINE) &&
                     (y_r < LIM_FINE) && (y_r > -LIM_FINE);
  assign coarse_ok = (x_r < LIM_COARSE) && (x_r > -LIM_COARSE) &&
                     (y_r < LIM_COARSE) && (y_r > -LIM_COARSE);
  assign arc_full  = arc_rounded(5'(it_r), TSH);
  assign arc_z     = signed'(ZW'(arc_full));
  assign dx        = y_r >>> it_r;
  assign dy        = x_r >>> it_r;
  assign done      = done_r;
  assign z_out     = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            if (y_in == '0) begin
              done_r <= 1'b1;
            end else begin
              state_r <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (!fine_ok) state_r <= C_ITER;
        end
        C_ITER: begin
          if (it_r == IW'(NIT - 1)) begin
            state_r <= C_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        it_r <= '0;
        if (start) begin
          if (y_in == '0) begin
            z_r <= (x_in < 0) ? HALF : '0;
          end else if (x_in < 0) begin
            if (y_in > 0) begin
              x_r <= y_in;
              y_r <= -x_in;
              z_r <= QUARTER;
            end else begin
              x_r <= -y_in;
              y_r <= x_in;
              z_r <= -QUARTER;
            end
          end else begin
            x_r <= x_in;
            y_r <= y_in;
            z_r <= '0;
          end
        end
      end
      C_NORM: begin
        // Jump eight doublings at once while both stay far from the limit.
        if (coarse_ok) begin
          x_r <= x_r <<< 8;
          y_r <= y_r <<< 8;
        end else if (fine_ok) begin
          x_r <= x_r <<< 1;
          y_r <= y_r <<< 1;
        end
      end
      C_ITER: begin
        it_r <= it_r + IW'(1);
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + arc_z;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - arc_z;
        end
      end
      default: it_r <= '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/tcc_back.sv
`default_nettype none

module tcc_back import tcc_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  tcc_item_t               q_item,
  input  wire logic [7:0]         adj_x,
  input  wire logic [7:0]         adj_y,
  input  wire logic [7:0]         adj_z,
  input  wire logic signed [19:0] hi_x,
  input  wire logic signed [19:0] hi_y,
  input  wire logic signed [19:0] hi_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_roll,
  output logic [15:0]             out_pitch,
  output logic [15:0]             out_heading
);

  localparam int ZW = ANGLE_BITS + 2;

  typedef enum logic [21:0] {
    B_IDLE  = 22'h000001, B_MX    = 22'h000002, B_MY    = 22'h000004,
    B_MZ    = 22'h000008, B_AYY   = 22'h000010, B_AZZ   = 22'h000020,
    B_AXX   = 22'h000040, B_SQ1   = 22'h000080, B_ROLL  = 22'h000100,
    B_PITCH = 22'h000200, B_AYMY  = 22'h000400, B_AZMZ  = 22'h000800,
    B_DIFF  = 22'h001000, B_HX    = 22'h002000, B_MYAZ  = 22'h004000,
    B_MZAY  = 22'h008000, B_SQ2   = 22'h010000, B_HY    = 22'h020000,
    B_LVX   = 22'h040000, B_LVY   = 22'h080000, B_HEAD  = 22'h100000,
    B_OUT   = 22'h200000
  } back_state_t;

  back_state_t state_r, step_next;
  logic        launched_r, out_valid_r;
  tcc_item_t   item_r;

  logic signed [MAG_W-1:0] mx_r, my_r, mz_r;
  logic [31:0]             r1sq_r, rsq_r, sq_r;
  logic signed [63:0]      t0_r, t1_r, hx_r, hy_r;
  logic [63:0]             sqn_r, sqroot_r, sqbit_r, sq_in, sq_try;
  logic [15:0]             roll_r, pitch_r, head_r;
  logic [15:0]             o_roll_r, o_pitch_r, o_head_r;

  logic        is_mul, is_sq, is_cor, step_done;
  logic [63:0] mul_a, mul_b, mul_c, mul_p;
  logic        mul_done, cor_done;
  logic signed [63:0]   cor_y, cor_x;
  logic signed [ZW-1:0] cor_z;
  logic signed [17:0]   bam;
  logic [15:0]          pitch_clamped;
  logic [8:0]           gain_x, gain_y, gain_z;
  logic signed [63:0]   ax64, ay64, az64, mx64, my64, mz64, abs_ax;

  assign gain_x = {1'b0, adj_x} + 9'd128;
  assign gain_y = {1'b0, adj_y} + 9'd128;
  assign gain_z = {1'b0, adj_z} + 9'd128;
  assign ax64   = 64'(item_r.ax);
  assign ay64   = 64'(item_r.ay);
  assign az64   = 64'(item_r.az);
  assign mx64   = 64'(mx_r);
  assign my64   = 64'(my_r);
  assign mz64   = 64'(mz_r);
  assign abs_ax = (item_r.ax < 0) ? -ax64 : ax64;

  assign q_pop       = (state_r == B_IDLE) && !q_empty;
  assign out_valid   = out_valid_r;
  assign out_roll    = o_roll_r;
  assign out_pitch   = o_pitch_r;
  assign out_heading = o_head_r;

  // Angle accumulator units to 65536 per turn, rounding half up when scaling down.
  if (ANGLE_BITS > 16) begin : g_down
    localparam int SH = ANGLE_BITS - 16;
    logic signed [ZW:0] rsum;
    assign rsum = (ZW + 1)'(cor_z) + (ZW + 1)'(64'd1 << (SH - 1));
    assign bam  = 18'(rsum >>> SH);
  end else begin : g_up
    localparam int SH = 16 - ANGLE_BITS;
    assign bam = 18'(cor_z) <<< SH;
  end

  always_comb begin
    if (bam > 18'sd16384) begin
      pitch_clamped = 16'd16384;
    end else if (bam < -18'sd16384) begin
      pitch_clamped = 16'hC000;
    end else begin
      pitch_clamped = bam[15:0];
    end
  end

  always_comb begin
    is_mul    = 1'b0;
    is_sq     = 1'b0;
    is_cor    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_c     = '0;
    sq_in     = '0;
    cor_y     = '0;
    cor_x     = '0;
    step_next = B_IDLE;
    case (state_r)
      B_MX: begin
        is_mul = 1'b1; mul_a = 64'(item_r.mx); mul_b = {55'd0, gain_x};
        mul_c = 64'(hi_x) <<< 4; step_next = B_MY;
      end
      B_MY: begin
        is_mul = 1'b1; mul_a = 64'(item_r.my); mul_b = {55'd0, gain_y};
        mul_c = 64'(hi_y) <<< 4; step_next = B_MZ;
      end
      B_MZ: begin
        is_mul = 1'b1; mul_a = 64'(item_r.mz); mul_b = {55'd0, gain_z};
        mul_c = 64'(hi_z) <<< 4; step_next = B_AYY;
      end
      B_AYY: begin
        is_mul = 1'b1; mul_a = ay64; mul_b = ay64; step_next = B_AZZ;
      end
      B_AZZ: begin
        is_mul = 1'b1; mul_a = az64; mul_b = az64; mul_c = t0_r; step_next = B_AXX;
      end
      B_AXX: begin
        is_mul = 1'b1; mul_a = ax64; mul_b = ax64; mul_c = {32'd0, r1sq_r};
        step_next = B_SQ1;
      end
      B_SQ1: begin
        is_sq = 1'b1; sq_in = {r1sq_r, 32'd0}; step_next = B_ROLL;
      end
      B_ROLL: begin
        is_cor = 1'b1; cor_y = ay64; cor_x = az64; step_next = B_PITCH;
      end
      B_PITCH: begin
        is_cor = 1'b1; cor_y = -ax64 <<< 16; cor_x = {32'd0, sq_r};
        case (item_r.kind)
          TILT_GENERAL: step_next = B_AYMY;
          TILT_LEVEL:   step_next = B_LVX;
          default:      step_next = B_HEAD;
        endcase
      end
      B_AYMY: begin
        is_mul = 1'b1; mul_a = ay64; mul_b = my64; step_next = B_AZMZ;
      end
      B_AZMZ: begin
        is_mul = 1'b1; mul_a = -az64; mul_b = mz64; mul_c = t0_r; step_next = B_DIFF;
      end
      B_DIFF: begin
        is_mul = 1'b1; mul_a = -ax64; mul_b = t0_r; step_next = B_HX;
      end
      B_HX: begin
        is_mul = 1'b1; mul_a = mx64; mul_b = {32'd0, r1sq_r}; mul_c = t1_r;
        step_next = B_MYAZ;
      end
      B_MYAZ: begin
        is_mul = 1'b1; mul_a = my64; mul_b = az64; step_next = B_MZAY;
      end
      B_MZAY: begin
        is_mul = 1'b1; mul_a = mz64; mul_b = ay64; mul_c = t0_r; step_next = B_SQ2;
      end
      B_SQ2: begin
        is_sq = 1'b1; sq_in = {16'd0, rsq_r, 16'd0}; step_next = B_HY;
      end
      B_HY: begin
        is_mul = 1'b1; mul_a = t0_r >>> 8; mul_b = {32'd0, sq_r}; step_next = B_HEAD;
      end
      B_LVX: begin
        is_mul = 1'b1; mul_a = ax64; mul_b = mz64; step_next = B_LVY;
      end
      B_LVY: begin
        is_mul = 1'b1; mul_a = my64; mul_b = abs_ax; step_next = B_HEAD;
      end
      B_HEAD: begin
        is_cor = 1'b1; cor_y = hy_r; cor_x = hx_r; step_next = B_OUT;
      end
      default: step_next = B_IDLE;
    endcase
  end

  assign sq_try    = sqroot_r + sqbit_r;
  assign step_done = launched_r && ((is_mul && mul_done) ||
                                    (is_sq && (sqbit_r == '0)) ||
                                    (is_cor && cor_done));

  tcc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (is_mul && !launched_r),
    .a     (mul_a),
    .b     (mul_b),
    .c     (mul_c),
    .done  (mul_done),
    .p     (mul_p)
  );

  tcc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (is_cor && !launched_r),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .z_out (cor_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) state_r <= B_MX;
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) state_r <= B_IDLE;
        end
        default: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (step_done) begin
            launched_r <= 1'b0;
            state_r    <= step_next;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;

    // Bitwise square root, one result bit per cycle.
    if (is_sq && !launched_r) begin
      sqn_r    <= sq_in;
      sqroot_r <= '0;
      sqbit_r  <= 64'd1 << 62;
    end else if (is_sq && (sqbit_r != '0)) begin
      if (sqn_r >= sq_try) begin
        sqn_r    <= sqn_r - sq_try;
        sqroot_r <= (sqroot_r >> 1) + sqbit_r;
      end else begin
        sqroot_r <= sqroot_r >> 1;
      end
      sqbit_r <= sqbit_r >> 2;
    end

    if (step_done) begin
      case (state_r)
        B_MX:    mx_r   <= mul_p[MAG_W-1:0];
        B_MY:    my_r   <= mul_p[MAG_W-1:0];
        B_MZ:    mz_r   <= mul_p[MAG_W-1:0];
        B_AYY:   t0_r   <= mul_p;
        B_AZZ:   r1sq_r <= mul_p[31:0];
        B_AXX:   rsq_r  <= mul_p[31:0];
        B_SQ1:   sq_r   <= sqroot_r[31:0];
        B_ROLL:  roll_r <= bam[15:0];
        B_PITCH: begin
          pitch_r <= pitch_clamped;
          if (item_r.kind != TILT_GENERAL && item_r.kind != TILT_LEVEL) begin
            hx_r <= mx64;
            hy_r <= my64;
          end
        end
        B_AYMY:  t0_r   <= mul_p;
        B_AZMZ:  t0_r   <= mul_p;
        B_DIFF:  t1_r   <= mul_p;
        B_HX:    hx_r   <= mul_p;
        B_MYAZ:  t0_r   <= mul_p;
        B_MZAY:  t0_r   <= mul_p;
        B_SQ2:   sq_r   <= sqroot_r[31:0];
        B_HY:    hy_r   <= mul_p;
        B_LVX:   hx_r   <= mul_p;
        B_LVY:   hy_r   <= mul_p;
        B_HEAD:  head_r <= bam[15:0];
        default: t1_r   <= t1_r;
      endcase
    end

    if (state_r == B_OUT && (!out_valid_r || out_ready)) begin
      o_roll_r  <= roll_r;
      o_pitch_r <= pitch_r;
      o_head_r  <= head_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/tilt_compensated_compass_unit.sv
`default_nettype none

// Tilt-compensated compass. Each input beat carries one accelerometer sample
// and one magnetometer sample; each output beat carries roll, pitch and the
// tilt-compensated heading in binary angle units (65536 per turn).
// The input channel is taken by a front end that latches a new magnetometer
// sample when it is ready and not overflowed, classifies the accelerometer
// vector and pushes the beat into a two-entry queue. The back end pops one
// beat at a time and works it through a sequencer that shares one 64-bit
// multiplier, one bit-serial square root and one vectoring CORDIC (a
// normalizing phase, then one step per cycle). A beat with general tilt
// runs through more steps than one with a level or all-zero accelerometer;
// the sequencer sets the throughput, as the back end pops no new beat until
// it is through with the last one.
// The result sits in an output register; while the receiver stalls, the back
// end finishes the next beat and holds it until the register is free, and the
// queue keeps taking up to two beats.
// Reset (synchronous, active low) empties the queue, clears the held
// magnetometer sample to zero and loads the registers with their defaults.
// Registers are to be written over the APB port only while the block is idle; the block itself does not enforce this.

module tilt_compensated_compass_unit import tcc_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, 16 bits each
  input  wire logic [95:0] in_tdata,
  // mag_ready, mag_overflow
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // roll_angle, pitch_angle, heading, 16 bits each
  output logic [47:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [7:0]         adj_x_r, adj_y_r, adj_z_r;
  logic signed [19:0] hi_x_r, hi_y_r, hi_z_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  tcc_item_t q_in_item, q_out_item;
  logic      q_push, q_pop, q_full, q_empty;
  logic [15:0] res_roll, res_pitch, res_head;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_x_r <= 8'd128;
      adj_y_r <= 8'd128;
      adj_z_r <= 8'd128;
      hi_x_r  <= -20'sd165;
      hi_y_r  <= -20'sd3782;
      hi_z_r  <= 20'sd2357;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ADJ_X: adj_x_r <= cfg_pwdata[7:0];
        REG_ADJ_Y: adj_y_r <= cfg_pwdata[7:0];
        REG_ADJ_Z: adj_z_r <= cfg_pwdata[7:0];
        REG_HI_X:  hi_x_r  <= cfg_pwdata[19:0];
        REG_HI_Y:  hi_y_r  <= cfg_pwdata[19:0];
        REG_HI_Z:  hi_z_r  <= cfg_pwdata[19:0];
        default:   adj_x_r <= adj_x_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ADJ_X: cfg_prdata = {24'd0, adj_x_r};
      REG_ADJ_Y: cfg_prdata = {24'd0, adj_y_r};
      REG_ADJ_Z: cfg_prdata = {24'd0, adj_z_r};
      REG_HI_X:  cfg_prdata = {12'd0, hi_x_r};
      REG_HI_Y:  cfg_prdata = {12'd0, hi_y_r};
      REG_HI_Z:  cfg_prdata = {12'd0, hi_z_r};
      default:   cfg_prdata = '0;
    endcase
  end

  tcc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .accel_x      (in_tdata[15:0]),
    .accel_y      (in_tdata[31:16]),
    .accel_z      (in_tdata[47:32]),
    .mag_x        (in_tdata[63:48]),
    .mag_y        (in_tdata[79:64]),
    .mag_z        (in_tdata[95:80]),
    .mag_ready    (in_tuser[0]),
    .mag_overflow (in_tuser[1]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in_item)
  );

  tcc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out_item),
    .empty (q_empty)
  );

  tcc_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_item      (q_out_item),
    .adj_x       (adj_x_r),
    .adj_y       (adj_y_r),
    .adj_z       (adj_z_r),
    .hi_x        (hi_x_r),
    .hi_y        (hi_y_r),
    .hi_z        (hi_z_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_roll    (res_roll),
    .out_pitch   (res_pitch),
    .out_heading (res_head)
  );

  assign out_tdata = {res_head, res_pitch, res_roll};

  // The queue is never written when full nor read when empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // Pitch never leaves a quarter turn either way.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:16]) <= 16'sd16384 &&
                    $signed(out_tdata[31:16]) >= -16'sd16384))
    else $error("pitch out of range");

endmodule

`default_nettype wire
